[src/gocp_pkg.sv]
// ----------------------------------------------------------------------------
// gocp_pkg
// Types, codes and the control store for the glyph outline to cubic path
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package gocp_pkg;

    // input opcodes
    localparam logic [2:0] OPC_MOVE  = 3'd0;
    localparam logic [2:0] OPC_LINE  = 3'd1;
    localparam logic [2:0] OPC_QUAD  = 3'd2;
    localparam logic [2:0] OPC_CUBIC = 3'd3;
    localparam logic [2:0] OPC_END   = 3'd4;

    // configuration register indexes
    localparam logic CFG_DESIGN_SIZE   = 1'b0;
    localparam logic CFG_TARGET_HEIGHT = 1'b1;

    localparam logic [14:0] DESIGN_SIZE_RST   = 15'd2048;
    localparam logic [15:0] TARGET_HEIGHT_RST = 16'd1024;

    // divider setup
    localparam logic [5:0]  SCALE_BITS  = 6'd32;

    // ceil(2^17 / 3), exact for magnitudes below 2^17
    localparam logic [16:0] DIV3_RECIP  = 17'd43691;

    typedef enum logic [1:0] {
        KIND_MOVE   = 2'd0,
        KIND_LINE   = 2'd1,
        KIND_BEZIER = 2'd2,
        KIND_CLOSE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] ctrl_a_x;
        logic signed [15:0] ctrl_a_y;
        logic signed [15:0] ctrl_b_x;
        logic signed [15:0] ctrl_b_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] p1_x;
        logic signed [31:0] p1_y;
        logic signed [31:0] p2_x;
        logic signed [31:0] p2_y;
        logic signed [31:0] p3_x;
        logic signed [31:0] p3_y;
        logic               last;
    } t_out_item;

    // micro operations
    typedef enum logic [2:0] {
        UOP_JMP,
        UOP_LOAD,
        UOP_DIV,
        UOP_EMIT,
        UOP_END
    } t_uop;

    typedef enum logic [3:0] {
        SRC_AX,
        SRC_AY,
        SRC_BX,
        SRC_BY,
        SRC_EX,
        SRC_EY,
        SRC_TMP,
        SRC_C1X,
        SRC_C1Y,
        SRC_C2X,
        SRC_C2Y
    } t_src;

    typedef enum logic [2:0] {
        DST_P1X = 3'd0,
        DST_P1Y = 3'd1,
        DST_P2X = 3'd2,
        DST_P2Y = 3'd3,
        DST_P3X = 3'd4,
        DST_P3Y = 3'd5,
        DST_TMP = 3'd6
    } t_dst;

    typedef enum logic {
        COND_ALWAYS,
        COND_NO_MOVE
    } t_cond;

    typedef enum logic [1:0] {
        FLAG_KEEP,
        FLAG_CLEAR,
        FLAG_SET
    } t_flag;

    typedef logic [5:0] t_uaddr;

    typedef struct packed {
        t_uop   op;
        t_src   src;
        logic   mul;
        logic   div3;
        t_dst   dst;
        t_kind  kind;
        logic   last;
        t_cond  cond;
        t_uaddr target;
        logic   upd_cur;
        t_flag  flag;
    } t_uword;

    // program entry points
    localparam t_uaddr UA_MOVE      = 6'd0;
    localparam t_uaddr UA_MOVE_BODY = 6'd2;
    localparam t_uaddr UA_LINE      = 6'd8;
    localparam t_uaddr UA_CUBIC     = 6'd14;
    localparam t_uaddr UA_QUAD      = 6'd28;
    localparam t_uaddr UA_EOL       = 6'd50;
    localparam t_uaddr UA_EOL_DONE  = 6'd52;
    localparam t_uaddr UA_IGNORE    = 6'd53;

    function automatic t_uword uw_jmp(input t_cond c, input t_uaddr t);
        t_uword w;
        w        = '0;
        w.op     = UOP_JMP;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    function automatic t_uword uw_load(input t_src s, input logic m);
        t_uword w;
        w     = '0;
        w.op  = UOP_LOAD;
        w.src = s;
        w.mul = m;
        return w;
    endfunction

    function automatic t_uword uw_div(input logic d3, input t_dst d);
        t_uword w;
        w      = '0;
        w.op   = UOP_DIV;
        w.div3 = d3;
        w.dst  = d;
        return w;
    endfunction

    function automatic t_uword uw_emit(input t_kind k, input logic l);
        t_uword w;
        w      = '0;
        w.op   = UOP_EMIT;
        w.kind = k;
        w.last = l;
        return w;
    endfunction

    function automatic t_uword uw_end(input logic u, input t_flag f);
        t_uword w;
        w         = '0;
        w.op      = UOP_END;
        w.upd_cur = u;
        w.flag    = f;
        return w;
    endfunction

    function automatic t_uaddr entry_of(input logic [2:0] opc);
        t_uaddr a;
        unique case (opc)
            OPC_MOVE:  a = UA_MOVE;
            OPC_LINE:  a = UA_LINE;
            OPC_QUAD:  a = UA_QUAD;
            OPC_CUBIC: a = UA_CUBIC;
            OPC_END:   a = UA_EOL;
            default:   a = UA_IGNORE;
        endcase
        return a;
    endfunction

    // control store
    function automatic t_uword urom(input t_uaddr a);
        t_uword w;
        unique case (a)
            // move
            6'd0:  w = uw_jmp(COND_NO_MOVE, UA_MOVE_BODY);
            6'd1:  w = uw_emit(KIND_CLOSE, 1'b0);
            6'd2:  w = uw_load(SRC_EX, 1'b1);
            6'd3:  w = uw_div(1'b0, DST_P1X);
            6'd4:  w = uw_load(SRC_EY, 1'b1);
            6'd5:  w = uw_div(1'b0, DST_P1Y);
            6'd6:  w = uw_emit(KIND_MOVE, 1'b1);
            6'd7:  w = uw_end(1'b1, FLAG_CLEAR);
            // line
            6'd8:  w = uw_load(SRC_EX, 1'b1);
            6'd9:  w = uw_div(1'b0, DST_P1X);
            6'd10: w = uw_load(SRC_EY, 1'b1);
            6'd11: w = uw_div(1'b0, DST_P1Y);
            6'd12: w = uw_emit(KIND_LINE, 1'b1);
            6'd13: w = uw_end(1'b1, FLAG_KEEP);
            // cubic
            6'd14: w = uw_load(SRC_AX, 1'b1);
            6'd15: w = uw_div(1'b0, DST_P1X);
            6'd16: w = uw_load(SRC_AY, 1'b1);
            6'd17: w = uw_div(1'b0, DST_P1Y);
            6'd18: w = uw_load(SRC_BX, 1'b1);
            6'd19: w = uw_div(1'b0, DST_P2X);
            6'd20: w = uw_load(SRC_BY, 1'b1);
            6'd21: w = uw_div(1'b0, DST_P2Y);
            6'd22: w = uw_load(SRC_EX, 1'b1);
            6'd23: w = uw_div(1'b0, DST_P3X);
            6'd24: w = uw_load(SRC_EY, 1'b1);
            6'd25: w = uw_div(1'b0, DST_P3Y);
            6'd26: w = uw_emit(KIND_BEZIER, 1'b1);
            6'd27: w = uw_end(1'b1, FLAG_KEEP);
            // quadratic, elevated to cubic
            6'd28: w = uw_load(SRC_C1X, 1'b0);
            6'd29: w = uw_div(1'b1, DST_TMP);
            6'd30: w = uw_load(SRC_TMP, 1'b1);
            6'd31: w = uw_div(1'b0, DST_P1X);
            6'd32: w = uw_load(SRC_C1Y, 1'b0);
            6'd33: w = uw_div(1'b1, DST_TMP);
            6'd34: w = uw_load(SRC_TMP, 1'b1);
            6'd35: w = uw_div(1'b0, DST_P1Y);
            6'd36: w = uw_load(SRC_C2X, 1'b0);
            6'd37: w = uw_div(1'b1, DST_TMP);
            6'd38: w = uw_load(SRC_TMP, 1'b1);
            6'd39: w = uw_div(1'b0, DST_P2X);
            6'd40: w = uw_load(SRC_C2Y, 1'b0);
            6'd41: w = uw_div(1'b1, DST_TMP);
            6'd42: w = uw_load(SRC_TMP, 1'b1);
            6'd43: w = uw_div(1'b0, DST_P2Y);
            6'd44: w = uw_load(SRC_EX, 1'b1);
            6'd45: w = uw_div(1'b0, DST_P3X);
            6'd46: w = uw_load(SRC_EY, 1'b1);
            6'd47: w = uw_div(1'b0, DST_P3Y);
            6'd48: w = uw_emit(KIND_BEZIER, 1'b1);
            6'd49: w = uw_end(1'b1, FLAG_KEEP);
            // end of outline
            6'd50: w = uw_jmp(COND_NO_MOVE, UA_EOL_DONE);
            6'd51: w = uw_emit(KIND_CLOSE, 1'b1);
            6'd52: w = uw_end(1'b0, FLAG_SET);
            // undefined opcode and unused addresses
            default: w = uw_end(1'b0, FLAG_KEEP);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[src/glyph_outline_to_cubic_path.sv]
// ----------------------------------------------------------------------------
// glyph_outline_to_cubic_path
// Converts glyph outline commands into scaled move, line, cubic and close
// path transactions, raising quadratics to cubics.
// ----------------------------------------------------------------------------
// One outline command is taken at a time; o_in_ready stays low until its
// microprogram has finished. Every scaled coordinate costs one load step and
// one pass of the shared restoring divider (one quotient bit per cycle); a
// quadratic's control coordinates first take a load and a divide by three,
// which is a combinational reciprocal multiply. An emit step waits while the
// output register is still full and not being drained.
// A finished transaction waits in the output register while work goes on.
`default_nettype none

module glyph_outline_to_cubic_path (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire gocp_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output gocp_pkg::t_out_item      o_out,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);

    gocp_pkg::t_in_item  r_item;
    gocp_pkg::t_out_item r_out;
    logic                r_out_valid;

    logic [14:0]         r_ds;
    logic [15:0]         r_th;
    logic signed [15:0]  r_cur_x;
    logic signed [15:0]  r_cur_y;
    logic                r_no_move;

    logic                r_busy;
    gocp_pkg::t_uaddr    r_pc;

    logic signed [32:0]  r_prod;
    logic signed [15:0]  r_tmp;
    logic signed [31:0]  r_pt [0:5];

    logic                r_div_run;
    logic [5:0]          r_cnt;
    logic [31:0]         r_dvd;
    logic [14:0]         r_rem;
    logic [14:0]         r_dsr;
    logic                r_neg;

    gocp_pkg::t_uword    w;
    logic signed [17:0]  src_val;
    logic signed [32:0]  mul_res;
    logic [32:0]         mag;
    logic [15:0]         shifted;
    logic [16:0]         trial;
    logic                qbit;
    logic [14:0]         n_rem;
    logic [31:0]         n_dvd;
    logic [31:0]         quot;
    logic [33:0]         recip;
    logic [15:0]         q3;
    logic                emit_ok;
    logic                emit_fire;
    logic                in_fire;

    assign o_in_ready  = !r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && !r_busy;
    assign emit_ok     = !r_out_valid || i_out_ready;
    assign emit_fire   = r_busy && (w.op == gocp_pkg::UOP_EMIT) && emit_ok;

    assign w = gocp_pkg::urom(r_pc);

    // operand select
    always_comb begin
        unique case (w.src)
            gocp_pkg::SRC_AX:  src_val = {{2{r_item.ctrl_a_x[15]}}, r_item.ctrl_a_x};
            gocp_pkg::SRC_AY:  src_val = {{2{r_item.ctrl_a_y[15]}}, r_item.ctrl_a_y};
            gocp_pkg::SRC_BX:  src_val = {{2{r_item.ctrl_b_x[15]}}, r_item.ctrl_b_x};
            gocp_pkg::SRC_BY:  src_val = {{2{r_item.ctrl_b_y[15]}}, r_item.ctrl_b_y};
            gocp_pkg::SRC_EX:  src_val = {{2{r_item.end_x[15]}}, r_item.end_x};
            gocp_pkg::SRC_EY:  src_val = {{2{r_item.end_y[15]}}, r_item.end_y};
            gocp_pkg::SRC_TMP: src_val = {{2{r_tmp[15]}}, r_tmp};
            gocp_pkg::SRC_C1X: src_val = {{2{r_cur_x[15]}}, r_cur_x}
                                       + {r_item.ctrl_a_x[15], r_item.ctrl_a_x, 1'b0};
            gocp_pkg::SRC_C1Y: src_val = {{2{r_cur_y[15]}}, r_cur_y}
                                       + {r_item.ctrl_a_y[15], r_item.ctrl_a_y, 1'b0};
            gocp_pkg::SRC_C2X: src_val = {{2{r_item.end_x[15]}}, r_item.end_x}
                                       + {r_item.ctrl_a_x[15], r_item.ctrl_a_x, 1'b0};
            gocp_pkg::SRC_C2Y: src_val = {{2{r_item.end_y[15]}}, r_item.end_y}
                                       + {r_item.ctrl_a_y[15], r_item.ctrl_a_y, 1'b0};
            default:           src_val = '0;
        endcase
    end

    assign mul_res = $signed(src_val[15:0]) * $signed({1'b0, r_th});

    // restoring divider step and divide by three
    always_comb begin
        mag     = r_prod[32] ? 33'(-r_prod) : 33'(r_prod);
        shifted = {r_rem, r_dvd[31]};
        trial   = {1'b0, shifted} - {2'b00, r_dsr};
        qbit    = !trial[16];
        n_rem   = qbit ? trial[14:0] : shifted[14:0];
        n_dvd   = {r_dvd[30:0], qbit};
        quot    = r_neg ? 32'(-r_dvd) : r_dvd;
        recip   = {17'b0, mag[16:0]} * {17'b0, gocp_pkg::DIV3_RECIP};
        q3      = r_prod[32] ? 16'(-recip[33:17]) : recip[32:17];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= '0;
            r_div_run   <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_ds        <= gocp_pkg::DESIGN_SIZE_RST;
            r_th        <= gocp_pkg::TARGET_HEIGHT_RST;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_no_move   <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    gocp_pkg::CFG_DESIGN_SIZE:   r_ds <= i_cfg_data[14:0];
                    gocp_pkg::CFG_TARGET_HEIGHT: r_th <= i_cfg_data;
                    default:                     r_th <= r_th;
                endcase
            end

            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (in_fire) begin
                r_item <= i_in;
                r_pc   <= gocp_pkg::entry_of(i_in.opcode);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                unique case (w.op)
                    gocp_pkg::UOP_JMP: begin
                        if (w.cond == gocp_pkg::COND_NO_MOVE && r_no_move) begin
                            r_pc <= w.target;
                        end else begin
                            r_pc <= r_pc + 6'd1;
                        end
                    end
                    gocp_pkg::UOP_LOAD: begin
                        r_prod <= w.mul ? mul_res : {{15{src_val[17]}}, src_val};
                        r_pc   <= r_pc + 6'd1;
                    end
                    gocp_pkg::UOP_DIV: begin
                        if (w.div3) begin
                            r_tmp <= q3;
                            r_pc  <= r_pc + 6'd1;
                        end else if (!r_div_run) begin
                            r_div_run <= 1'b1;
                            r_neg     <= r_prod[32];
                            r_rem     <= '0;
                            r_dvd     <= mag[31:0];
                            r_cnt     <= gocp_pkg::SCALE_BITS;
                            r_dsr     <= (r_ds == '0) ? 15'd1 : r_ds;
                        end else if (r_cnt != '0) begin
                            r_dvd <= n_dvd;
                            r_rem <= n_rem;
                            r_cnt <= r_cnt - 6'd1;
                        end else begin
                            r_div_run <= 1'b0;
                            r_pc      <= r_pc + 6'd1;
                            if (w.dst == gocp_pkg::DST_TMP) begin
                                r_tmp <= quot[15:0];
                            end else begin
                                r_pt[w.dst] <= quot;
                            end
                        end
                    end
                    gocp_pkg::UOP_EMIT: begin
                        if (emit_ok) begin
                            r_out.kind  <= w.kind;
                            r_out.last  <= w.last;
                            r_out.p1_x  <= (w.kind == gocp_pkg::KIND_CLOSE) ? '0 : r_pt[0];
                            r_out.p1_y  <= (w.kind == gocp_pkg::KIND_CLOSE) ? '0 : r_pt[1];
                            r_out.p2_x  <= (w.kind == gocp_pkg::KIND_BEZIER) ? r_pt[2] : '0;
                            r_out.p2_y  <= (w.kind == gocp_pkg::KIND_BEZIER) ? r_pt[3] : '0;
                            r_out.p3_x  <= (w.kind == gocp_pkg::KIND_BEZIER) ? r_pt[4] : '0;
                            r_out.p3_y  <= (w.kind == gocp_pkg::KIND_BEZIER) ? r_pt[5] : '0;
                            r_pc        <= r_pc + 6'd1;
                        end
                    end
                    gocp_pkg::UOP_END: begin
                        r_busy <= 1'b0;
                        if (w.upd_cur) begin
                            r_cur_x <= r_item.end_x;
                            r_cur_y <= r_item.end_y;
                        end
                        if (w.flag == gocp_pkg::FLAG_CLEAR) begin
                            r_no_move <= 1'b0;
                        end else if (w.flag == gocp_pkg::FLAG_SET) begin
                            r_no_move <= 1'b1;
                        end
                    end
                    default: begin
                        r_busy <= 1'b0;
                    end
                endcase
            end
        end
    end

    // divider only runs inside a program
    a_div_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_run |-> r_busy)
        else $error("divider running while sequencer idle");

    // iteration count never exceeds a full scale divide
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_run |-> (r_cnt <= gocp_pkg::SCALE_BITS))
        else $error("divider count out of range");

    // close path transactions carry no points
    a_close_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == gocp_pkg::KIND_CLOSE) |->
            (r_out.p1_x == '0 && r_out.p1_y == '0 && r_out.p2_x == '0 &&
             r_out.p2_y == '0 && r_out.p3_x == '0 && r_out.p3_y == '0))
        else $error("close path with nonzero points");

    // an accepted command starts its program
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_busy && !r_div_run))
        else $error("accepted command did not start");

endmodule

`default_nettype wire
